>>> rtl/core/rhsl_pkg.sv
package rhsl_pkg;

  localparam int PixW      = 8;
  localparam int QuoW      = 16;
  localparam int NumW      = PixW + QuoW;
  localparam int HueW      = 15;
  localparam int DivBits   = 2;
  localparam int DivStages = QuoW / DivBits;

  localparam int Sector64     = 3840;
  localparam int HueFull64    = 6 * Sector64;
  localparam int PixMax       = (1 << PixW) - 1;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic            defined;
    logic [QuoW-1:0] light;
    logic [PixW-1:0] alpha;
  } div_tag_t;

  typedef struct packed {
    logic            q;
    logic [PixW-1:0] rem;
  } div_bit_t;

  // one restoring step: shift in the next numerator bit, subtract when it fits
  function automatic div_bit_t div_bit(input logic [PixW-1:0] rem, input logic nb,
                                       input logic [PixW-1:0] den);
    logic [PixW:0] t;
    div_bit_t      res;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      res.q   = 1'b1;
      res.rem = PixW'(t - {1'b0, den});
    end else begin
      res.q   = 1'b0;
      res.rem = t[PixW-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rhsl_div_pipe.sv
module rhsl_div_pipe import rhsl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  div_tag_t        in_tag,
  input  logic [NumW-1:0] in_hue_num,
  input  logic [PixW-1:0] in_hue_den,
  input  logic [NumW-1:0] in_sat_num,
  input  logic [PixW-1:0] in_sat_den,
  output logic            out_vld,
  output div_tag_t        out_tag,
  output logic [QuoW-1:0] out_hue_q,
  output logic [QuoW-1:0] out_sat_q
);

  logic [DivStages-1:0] vld_r;
  div_tag_t             tag_r    [DivStages];
  logic [PixW-1:0]      hrem_r   [DivStages];
  logic [QuoW-1:0]      hlow_r   [DivStages];
  logic [QuoW-1:0]      hq_r     [DivStages];
  logic [PixW-1:0]      hden_r   [DivStages];
  logic [PixW-1:0]      srem_r   [DivStages];
  logic [QuoW-1:0]      slow_r   [DivStages];
  logic [QuoW-1:0]      sq_r     [DivStages];
  logic [PixW-1:0]      sden_r   [DivStages];

  logic [PixW-1:0]      hrem_nxt [DivStages];
  logic [QuoW-1:0]      hlow_nxt [DivStages];
  logic [QuoW-1:0]      hq_nxt   [DivStages];
  logic [PixW-1:0]      hden_nxt [DivStages];
  logic [PixW-1:0]      srem_nxt [DivStages];
  logic [QuoW-1:0]      slow_nxt [DivStages];
  logic [QuoW-1:0]      sq_nxt   [DivStages];
  logic [PixW-1:0]      sden_nxt [DivStages];
  div_tag_t             tag_nxt  [DivStages];

  always_comb begin
    div_bit_t        hs;
    div_bit_t        ss;
    logic [PixW-1:0] hr;
    logic [PixW-1:0] sr;
    logic [PixW-1:0] hd;
    logic [PixW-1:0] sd;
    logic [QuoW-1:0] hl;
    logic [QuoW-1:0] sl;
    logic [QuoW-1:0] hq;
    logic [QuoW-1:0] sq;
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        hr         = in_hue_num[NumW-1:QuoW];
        hl         = in_hue_num[QuoW-1:0];
        hq         = '0;
        hd         = in_hue_den;
        sr         = in_sat_num[NumW-1:QuoW];
        sl         = in_sat_num[QuoW-1:0];
        sq         = '0;
        sd         = in_sat_den;
        tag_nxt[k] = in_tag;
      end else begin
        hr         = hrem_r[k-1];
        hl         = hlow_r[k-1];
        hq         = hq_r[k-1];
        hd         = hden_r[k-1];
        sr         = srem_r[k-1];
        sl         = slow_r[k-1];
        sq         = sq_r[k-1];
        sd         = sden_r[k-1];
        tag_nxt[k] = tag_r[k-1];
      end
      for (int b = 0; b < DivBits; b++) begin
        hs = div_bit(hr, hl[QuoW-1], hd);
        ss = div_bit(sr, sl[QuoW-1], sd);
        hr = hs.rem;
        sr = ss.rem;
        hl = {hl[QuoW-2:0], 1'b0};
        sl = {sl[QuoW-2:0], 1'b0};
        hq = {hq[QuoW-2:0], hs.q};
        sq = {sq[QuoW-2:0], ss.q};
      end
      hrem_nxt[k] = hr;
      hlow_nxt[k] = hl;
      hq_nxt[k]   = hq;
      hden_nxt[k] = hd;
      srem_nxt[k] = sr;
      slow_nxt[k] = sl;
      sq_nxt[k]   = sq;
      sden_nxt[k] = sd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DivStages-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DivStages; k++) begin
      tag_r[k]  <= tag_nxt[k];
      hrem_r[k] <= hrem_nxt[k];
      hlow_r[k] <= hlow_nxt[k];
      hq_r[k]   <= hq_nxt[k];
      hden_r[k] <= hden_nxt[k];
      srem_r[k] <= srem_nxt[k];
      slow_r[k] <= slow_nxt[k];
      sq_r[k]   <= sq_nxt[k];
      sden_r[k] <= sden_nxt[k];
    end
  end

  assign out_vld   = vld_r[DivStages-1];
  assign out_tag   = tag_r[DivStages-1];
  assign out_hue_q = hq_r[DivStages-1];
  assign out_sat_q = sq_r[DivStages-1];

  // remainder stays below the divisor in the last stage whenever it holds a live entry
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DivStages-1] |-> hrem_r[DivStages-1] < hden_r[DivStages-1]
                        && srem_r[DivStages-1] < sden_r[DivStages-1])
    else $error("divider remainder out of range");

  a_vld_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(in_vld, DivStages))
    else $error("divider valid without matching entry");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> in_hue_den != '0 && in_sat_den != '0)
    else $error("divider fed a zero divisor");

endmodule

>>> rtl/core/rgb_to_hsl_converter.sv
// A pixel accepted at a clock edge passes 3 front stages, 8 divider stages and 1 output
// register before its strobe.
// Throughput: one pixel per clock; busy stays low and a new transaction may start every cycle.
// Hue and saturation quotients come from an 8-stage restoring divider, 2 bits per stage.
// Reset (rst_n low, synchronous) drops every transaction in flight and clears out_valid.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rgb_to_hsl_converter import rhsl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [PixW-1:0] in_red,
  input  logic [PixW-1:0] in_green,
  input  logic [PixW-1:0] in_blue,
  input  logic [PixW-1:0] in_alpha_in,
  output logic            out_valid,
  output logic [HueW-1:0] out_hue,
  output logic            out_hue_defined,
  output logic [QuoW-1:0] out_saturation,
  output logic [QuoW-1:0] out_lightness,
  output logic [PixW-1:0] out_alpha_out
);

  logic accept;

  // stage 1: max, min, sector, signed difference
  logic                   s1_vld_r;
  logic [PixW-1:0]        s1_hi_r, s1_hi_nxt;
  logic [PixW-1:0]        s1_lo_r, s1_lo_nxt;
  sector_t                s1_sec_r, s1_sec_nxt;
  logic signed [PixW:0]   s1_diff_r, s1_diff_nxt;
  logic [PixW-1:0]        s1_alpha_r;

  // stage 2: chroma, sum, scaled difference
  logic                   s2_vld_r;
  logic [PixW-1:0]        s2_c_r, s2_c_nxt;
  logic [PixW:0]          s2_sum_r, s2_sum_nxt;
  logic signed [20:0]     s2_hterm_r, s2_hterm_nxt;
  sector_t                s2_sec_r;
  logic [PixW-1:0]        s2_alpha_r;

  // stage 3: numerators and divisors
  logic                   s3_vld_r;
  div_tag_t               s3_tag_r, s3_tag_nxt;
  logic [NumW-1:0]        s3_hnum_r, s3_hnum_nxt;
  logic [PixW-1:0]        s3_hden_r, s3_hden_nxt;
  logic [NumW-1:0]        s3_snum_r, s3_snum_nxt;
  logic [PixW-1:0]        s3_sden_r, s3_sden_nxt;

  logic [22:0]            off;
  logic signed [24:0]     hnum;
  logic [PixW:0]          sum_dev;

  logic                   dv;
  div_tag_t               dtag;
  logic [QuoW-1:0]        dhq;
  logic [QuoW-1:0]        dsq;

  logic                   out_valid_r;
  logic [HueW-1:0]        hue_r;
  logic                   defined_r;
  logic [QuoW-1:0]        sat_r;
  logic [QuoW-1:0]        light_r;
  logic [PixW-1:0]        alpha_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // red wins ties over green, green over blue
  always_comb begin
    if (in_red >= in_green && in_red >= in_blue) begin
      s1_hi_nxt   = in_red;
      s1_sec_nxt  = SEC_RED;
      s1_diff_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      s1_hi_nxt   = in_green;
      s1_sec_nxt  = SEC_GREEN;
      s1_diff_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      s1_hi_nxt   = in_blue;
      s1_sec_nxt  = SEC_BLUE;
      s1_diff_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
    if (in_red <= in_green && in_red <= in_blue) begin
      s1_lo_nxt = in_red;
    end else if (in_green <= in_blue) begin
      s1_lo_nxt = in_green;
    end else begin
      s1_lo_nxt = in_blue;
    end
  end

  always_comb begin
    s2_c_nxt     = s1_hi_r - s1_lo_r;
    s2_sum_nxt   = {1'b0, s1_hi_r} + {1'b0, s1_lo_r};
    s2_hterm_nxt = 21'(s1_diff_r) * 21'sd3840;
  end

  always_comb begin
    case (s2_sec_r)
      SEC_RED:   off = s2_hterm_r < 21'sd0 ? 23'(s2_c_r * 23'(HueFull64)) : '0;
      SEC_GREEN: off = 23'(s2_c_r * 23'(2 * Sector64));
      SEC_BLUE:  off = 23'(s2_c_r * 23'(4 * Sector64));
      default:   off = '0;
    endcase
    hnum = 25'(s2_hterm_r) + $signed({2'b00, off});
    sum_dev = s2_sum_r >= (PixW+1)'(PixMax) ? s2_sum_r - (PixW+1)'(PixMax)
                                            : (PixW+1)'(PixMax) - s2_sum_r;
    s3_tag_nxt.defined = s2_c_r != '0;
    s3_tag_nxt.alpha   = s2_alpha_r;
    // sum * 65535 / 510 is sum * 257 / 2
    s3_tag_nxt.light   = QuoW'(({8'b0, s2_sum_r} + {s2_sum_r, 8'b0}) >> 1);
    s3_hnum_nxt = hnum[NumW-1:0];
    s3_snum_nxt = {s2_c_r, 16'b0} - {16'b0, s2_c_r};
    if (s2_c_r != '0) begin
      s3_hden_nxt = s2_c_r;
      s3_sden_nxt = PixW'((PixW+1)'(PixMax) - sum_dev);
    end else begin
      s3_hden_nxt = PixW'(1);
      s3_sden_nxt = PixW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= accept;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    s1_hi_r    <= s1_hi_nxt;
    s1_lo_r    <= s1_lo_nxt;
    s1_sec_r   <= s1_sec_nxt;
    s1_diff_r  <= s1_diff_nxt;
    s1_alpha_r <= in_alpha_in;
    s2_c_r     <= s2_c_nxt;
    s2_sum_r   <= s2_sum_nxt;
    s2_hterm_r <= s2_hterm_nxt;
    s2_sec_r   <= s1_sec_r;
    s2_alpha_r <= s1_alpha_r;
    s3_tag_r   <= s3_tag_nxt;
    s3_hnum_r  <= s3_hnum_nxt;
    s3_hden_r  <= s3_hden_nxt;
    s3_snum_r  <= s3_snum_nxt;
    s3_sden_r  <= s3_sden_nxt;
    hue_r      <= dtag.defined ? dhq[HueW-1:0] : '0;
    defined_r  <= dtag.defined;
    sat_r      <= dtag.defined ? dsq : '0;
    light_r    <= dtag.light;
    alpha_r    <= dtag.alpha;
  end

  rhsl_div_pipe u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (s3_vld_r),
    .in_tag     (s3_tag_r),
    .in_hue_num (s3_hnum_r),
    .in_hue_den (s3_hden_r),
    .in_sat_num (s3_snum_r),
    .in_sat_den (s3_sden_r),
    .out_vld    (dv),
    .out_tag    (dtag),
    .out_hue_q  (dhq),
    .out_sat_q  (dsq)
  );

  assign out_valid       = out_valid_r;
  assign out_hue         = hue_r;
  assign out_hue_defined = defined_r;
  assign out_saturation  = sat_r;
  assign out_lightness   = light_r;
  assign out_alpha_out   = alpha_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, DivStages + 4))
    else $error("result without an accepted transaction");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hue_defined |-> out_hue == '0 && out_saturation == '0)
    else $error("gray pixel with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HueW'(HueFull64))
    else $error("hue beyond full circle");

  a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hue_defined |-> out_saturation != '0)
    else $error("chromatic pixel with zero saturation");

endmodule

>>> dv/testbench.sv
module testbench;
  import rhsl_pkg::*;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic            defined;
    logic [QuoW-1:0] sat;
    logic [QuoW-1:0] light;
    logic [PixW-1:0] alpha;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t pending_hsl[$];
    int   errors;
    int   pixels;
    int   grays;
    int   checked;

    function new();
      errors  = 0;
      pixels  = 0;
      grays   = 0;
      checked = 0;
    endfunction

    function hsl_t predict_hsl(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                               input logic [PixW-1:0] b, input logic [PixW-1:0] a);
      int      hi;
      int      lo;
      int      chroma;
      int      sum;
      int      diff;
      int      num;
      int      sum_dev;
      int      denom;
      int      quo;
      sector_t sec;
      hsl_t    res;
      hi  = int'((r >= g && r >= b) ? r : ((g >= b) ? g : b));
      lo  = int'((r <= g && r <= b) ? r : ((g <= b) ? g : b));
      chroma = hi - lo;
      sum = hi + lo;
      res.hue     = '0;
      res.defined = 1'b0;
      res.sat     = '0;
      res.light   = QuoW'((sum * PixMax * 257) / (2 * PixMax));
      res.alpha   = a;
      if (chroma != 0) begin
        if (hi == int'(r)) sec = SEC_RED;
        else if (hi == int'(g)) sec = SEC_GREEN;
        else sec = SEC_BLUE;
        case (sec)
          SEC_RED: begin
            diff = int'(g) - int'(b);
            num  = Sector64 * diff;
          end
          SEC_GREEN: begin
            diff = int'(b) - int'(r);
            num  = Sector64 * diff + 2 * Sector64 * chroma;
          end
          default: begin
            diff = int'(r) - int'(g);
            num  = Sector64 * diff + 4 * Sector64 * chroma;
          end
        endcase
        if (num < 0) num += HueFull64 * chroma;
        quo = num / chroma;
        if (quo > HueFull64 - 1) quo = HueFull64 - 1;
        res.hue     = HueW'(quo);
        res.defined = 1'b1;
        sum_dev = (sum >= PixMax) ? sum - PixMax : PixMax - sum;
        denom   = PixMax - sum_dev;
        if (denom != 0) begin
          quo = (chroma * 65535) / denom;
          if (quo > 65535) quo = 65535;
          res.sat = QuoW'(quo);
        end
      end
      return res;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function void note_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                             input logic [PixW-1:0] b, input logic [PixW-1:0] a);
      pixels++;
      if (r == g && g == b) grays++;
      pending_hsl.push_back(predict_hsl(r, g, b, a));
    endfunction

    task check_result(input hsl_t got);
      hsl_t want;
      if (pending_hsl.size() == 0) begin
        report("result with no transaction pending");
        return;
      end
      want = pending_hsl.pop_front();
      checked++;
      if (got.hue !== want.hue)
        report($sformatf("hue got %0d want %0d", got.hue, want.hue));
      if (got.defined !== want.defined)
        report($sformatf("hue_defined got %0b want %0b", got.defined, want.defined));
      if (got.sat !== want.sat)
        report($sformatf("saturation got %0d want %0d", got.sat, want.sat));
      if (got.light !== want.light)
        report($sformatf("lightness got %0d want %0d", got.light, want.light));
      if (got.alpha !== want.alpha)
        report($sformatf("alpha got %0d want %0d", got.alpha, want.alpha));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [PixW-1:0] in_red = '0;
  logic [PixW-1:0] in_green = '0;
  logic [PixW-1:0] in_blue = '0;
  logic [PixW-1:0] in_alpha_in = '0;
  logic            out_valid;
  logic [HueW-1:0] out_hue;
  logic            out_hue_defined;
  logic [QuoW-1:0] out_saturation;
  logic [QuoW-1:0] out_lightness;
  logic [PixW-1:0] out_alpha_out;

  hsl_scoreboard sb;
  hsl_t          seen;

  logic [31:0] corner_pixels [20] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFF0000FF, 32'h00FF0080, 32'h0000FF7F,
    32'h00FFFF01, 32'hFF00FFFE, 32'hFFFF0055, 32'hFFFF80AA, 32'h40FFFF33,
    32'hFF40FFCC, 32'hFF102010, 32'h80808080, 32'h01000002, 32'hFFFEFE03,
    32'hFFFFFE04, 32'h7F807F05, 32'h80007F06, 32'h12345678, 32'hFE01FF40
  };

  rgb_to_hsl_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha_in    (in_alpha_in),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_hue_defined(out_hue_defined),
    .out_saturation (out_saturation),
    .out_lightness  (out_lightness),
    .out_alpha_out  (out_alpha_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_pixel(in_red, in_green, in_blue, in_alpha_in);
    if (rst_n && out_valid) begin
      seen.hue     = out_hue;
      seen.defined = out_hue_defined;
      seen.sat     = out_saturation;
      seen.light   = out_lightness;
      seen.alpha   = out_alpha_out;
      sb.check_result(seen);
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] b, input logic [PixW-1:0] a,
                            input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_red      <= r;
    in_green    <= g;
    in_blue     <= b;
    in_alpha_in <= a;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_pixel(output logic [PixW-1:0] r, output logic [PixW-1:0] g,
                              output logic [PixW-1:0] b);
    logic [PixW-1:0] v;
    logic [PixW-1:0] w;
    int              odd;
    v = PixW'($urandom);
    w = PixW'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        r = v;
        g = v;
        b = v;
      end
      1: begin
        odd = $urandom_range(0, 2);
        r = (odd == 0) ? w : v;
        g = (odd == 1) ? w : v;
        b = (odd == 2) ? w : v;
      end
      2: begin
        r = PixW'($urandom_range(0, 3) * 85);
        g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        b = $urandom_range(0, 1) ? 8'hFE : 8'h01;
      end
      default: begin
        r = PixW'($urandom);
        g = PixW'($urandom);
        b = PixW'($urandom);
      end
    endcase
  endtask

  initial begin
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
    int              gap;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_pixels[i])
      send_pixel(corner_pixels[i][31:24], corner_pixels[i][23:16], corner_pixels[i][15:8],
                 corner_pixels[i][7:0], $urandom_range(0, 10));

    for (int i = 0; i < 1000; i++) begin
      if (i == 500) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.pending_hsl.size() != 0);
      end
      random_pixel(r, g, b);
      gap = ((i / 100) % 3 == 1) ? 0 : int'($urandom_range(0, 10));
      send_pixel(r, g, b, PixW'($urandom), gap);
    end
    start <= 1'b0;

    while (sb.pending_hsl.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending_hsl.size() != 0)
      sb.report($sformatf("%0d transactions without a result", sb.pending_hsl.size()));

    $display("Converted %0d pixels (%0d gray), including corner colors and max-channel ties;",
             sb.pixels, sb.grays);
    $display("checked %0d HSL transactions, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d transactions outstanding", sb.pending_hsl.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
